[hw/rtl/icl_pkg.sv]
// ----------------------------------------------------------------------------
// icl_pkg
// Shared types and constants for the implication closure engine: operation
// and status codes, the command word passed from front to back, and the
// stream word widths.
// ----------------------------------------------------------------------------
package icl_pkg;

  localparam int MASK_W        = 64;
  localparam int IDX_W         = 6;
  localparam int IN_TDATA_W    = 200;
  localparam int OUT_TDATA_W   = 72;
  localparam int DEF_ATTR_BITS = 64;
  localparam int DEF_MAX_RULES = 64;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_REPLACE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // masks arrive already cut to the configured attribute width
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [MASK_W-1:0]  prem;
    logic [MASK_W-1:0]  conc;
    logic [MASK_W-1:0]  set;
  } cmd_t;

endpackage

[hw/rtl/icl_front.sv]
// ----------------------------------------------------------------------------
// icl_front
// Input stage: takes stream words, decodes the operation, cuts the masks to
// the attribute width and holds the command until the queue takes it.
// ----------------------------------------------------------------------------
module icl_front #(
  parameter int ATTR_BITS = icl_pkg::DEF_ATTR_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [icl_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            q_push,
  input  logic                            q_ready,
  output icl_pkg::cmd_t                   q_cmd
);

  localparam logic [icl_pkg::MASK_W-1:0] AMASK =
    {icl_pkg::MASK_W{1'b1}} >> (icl_pkg::MASK_W - ATTR_BITS);

  logic          hold_valid_r;
  logic          hold_valid_nxt;
  icl_pkg::cmd_t hold_r;
  icl_pkg::cmd_t hold_nxt;
  icl_pkg::cmd_t decoded;
  logic          in_take;

  always_comb begin
    decoded.op   = icl_pkg::op_t'(in_tdata[1:0]);
    decoded.idx  = in_tdata[7:2];
    decoded.prem = in_tdata[71:8] & AMASK;
    decoded.conc = in_tdata[135:72] & AMASK;
    decoded.set  = in_tdata[199:136] & AMASK;
  end

  assign in_tready = !hold_valid_r || q_ready;
  assign in_take   = in_tvalid && in_tready;
  assign q_push    = hold_valid_r;
  assign q_cmd     = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (in_take) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = decoded;
    end else if (q_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

[hw/rtl/icl_queue.sv]
// ----------------------------------------------------------------------------
// icl_queue
// Short command queue between the front and the back so that either side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module icl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          push_ready,
  input  icl_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output icl_pkg::cmd_t pop_cmd
);

  icl_pkg::cmd_t                entry_r [icl_pkg::QDEPTH];
  logic [icl_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [icl_pkg::QPTR_W-1:0]   wr_ptr_nxt;
  logic [icl_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [icl_pkg::QPTR_W-1:0]   rd_ptr_nxt;
  logic [icl_pkg::QCNT_W-1:0]   cnt_r;
  logic [icl_pkg::QCNT_W-1:0]   cnt_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (cnt_r != icl_pkg::QCNT_W'(icl_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == icl_pkg::QPTR_W'(icl_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == icl_pkg::QPTR_W'(icl_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/icl_back.sv]
// ----------------------------------------------------------------------------
// icl_back
// Execution side: rule table memory, rule count, the forward-chaining scan
// (one rule per cycle, passes repeated until no rule adds anything) and the
// result register.
// ----------------------------------------------------------------------------
module icl_back #(
  parameter int ATTR_BITS = icl_pkg::DEF_ATTR_BITS,
  parameter int MAX_RULES = icl_pkg::DEF_MAX_RULES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  input  icl_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [icl_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int AW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW   = $clog2(MAX_RULES + 1);
  localparam int CMPW = (CW > icl_pkg::IDX_W) ? CW : icl_pkg::IDX_W;
  localparam int EW   = 2 * ATTR_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PRIME = 4'b0010,
    S_SCAN  = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [AW-1:0]           eval_r;
  logic [AW-1:0]           eval_nxt;
  logic                    grew_r;
  logic                    grew_nxt;
  logic [ATTR_BITS-1:0]    x_r;
  logic [ATTR_BITS-1:0]    x_nxt;
  logic [ATTR_BITS-1:0]    orig_r;
  logic [ATTR_BITS-1:0]    orig_nxt;

  logic [EW-1:0]           mem [MAX_RULES];
  logic [EW-1:0]           rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;

  logic                    out_valid_r;
  logic [icl_pkg::MASK_W-1:0] out_closed_r;
  logic                    out_done_r;
  icl_pkg::status_t        out_status_r;

  logic                    out_free;
  logic                    load;
  logic [ATTR_BITS-1:0]    ld_closed;
  logic                    ld_done;
  icl_pkg::status_t        ld_status;

  logic [ATTR_BITS-1:0]    cmd_prem;
  logic [ATTR_BITS-1:0]    cmd_conc;
  logic [ATTR_BITS-1:0]    cmd_set;
  logic [ATTR_BITS-1:0]    r_prem;
  logic [ATTR_BITS-1:0]    r_conc;
  logic                    hit;
  logic                    last;
  logic                    full;
  logic                    bad_idx;

  assign cmd_prem = cmd.prem[ATTR_BITS-1:0];
  assign cmd_conc = cmd.conc[ATTR_BITS-1:0];
  assign cmd_set  = cmd.set[ATTR_BITS-1:0];
  assign r_prem   = rd_data_r[ATTR_BITS-1:0];
  assign r_conc   = rd_data_r[EW-1:ATTR_BITS];

  assign hit      = ((r_prem & ~x_r) == '0) && ((r_conc & ~x_r) != '0);
  assign last     = (CW'(eval_r) == count_r - 1'b1);
  assign full     = (count_r == CW'(MAX_RULES));
  assign bad_idx  = (CMPW'(cmd.idx) >= CMPW'(count_r));
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    eval_nxt  = eval_r;
    grew_nxt  = grew_r;
    x_nxt     = x_r;
    orig_nxt  = orig_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(count_r);
    rd_addr   = '0;
    load      = 1'b0;
    ld_closed = '0;
    ld_done   = 1'b0;
    ld_status = icl_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            icl_pkg::OP_APPEND: begin
              load = 1'b1;
              if (full) begin
                ld_status = icl_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            icl_pkg::OP_REPLACE: begin
              load = 1'b1;
              if (bad_idx) begin
                ld_status = icl_pkg::ST_BAD_INDEX;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cmd.idx);
              end
            end
            icl_pkg::OP_QUERY: begin
              if (count_r == '0) begin
                load      = 1'b1;
                ld_closed = cmd_set;
                ld_done   = 1'b1;
              end else begin
                x_nxt     = cmd_set;
                orig_nxt  = cmd_set;
                state_nxt = S_PRIME;
              end
            end
            icl_pkg::OP_CLEAR: begin
              load      = 1'b1;
              count_nxt = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_PRIME: begin
        // first read of rule zero is in flight
        rd_addr   = '0;
        eval_nxt  = '0;
        grew_nxt  = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          x_nxt = x_r | r_conc;
        end
        if (last) begin
          rd_addr = '0;
          if (grew_r || hit) begin
            eval_nxt = '0;
            grew_nxt = 1'b0;
          end else begin
            state_nxt = S_HOLD;
          end
        end else begin
          rd_addr  = eval_r + 1'b1;
          eval_nxt = eval_r + 1'b1;
          grew_nxt = grew_r || hit;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load      = 1'b1;
          ld_closed = x_r;
          ld_done   = (x_r == orig_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_r <= eval_nxt;
    grew_r <= grew_nxt;
    x_r    <= x_nxt;
    orig_r <= orig_nxt;
    if (load) begin
      out_closed_r <= icl_pkg::MASK_W'(ld_closed);
      out_done_r   <= ld_done;
      out_status_r <= ld_status;
    end
  end

  // rule table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {cmd_conc, cmd_prem};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_status_r, out_done_r, out_closed_r};

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RULES))
    else $error("rule count above table size");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(eval_r) < count_r))
    else $error("scan index past rule count");

  a_grow_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_HOLD) |-> ((orig_r & ~x_r) == '0))
    else $error("closure lost a bit of the queried set");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (load && ld_status != icl_pkg::ST_OK) |-> (ld_closed == '0 && !ld_done))
    else $error("error result carries a closure");

  a_table_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !mem_we)
    else $error("rule table written during a scan");
`endif

endmodule

[hw/rtl/implication_closure_engine_core.sv]
// ----------------------------------------------------------------------------
// implication_closure_engine_core
// Rule table of premise/conclusion masks with append, replace, clear and a
// forward-chaining closure query.
// ----------------------------------------------------------------------------
// channel  dir  bits  contents (lsb first)
// in_      in   200   operation, rule_index, premise_mask, conclusion_mask,
//                     attribute_set
// out_     out  72    closed_set, already_closed, status, zero pad
//
// one word in, one word out, in order
// append, replace, clear and a query on an empty table: the word passes the
// front hold register and the queue, and the back loads the result register
// as it takes the command
// a query on N rules: the back first makes P passes (1 to N+1) over the
// table, one rule per cycle through the table's single read port
// reset clears the rule count and the handshakes; the table needs no clearing
// stalls on the result side back up through the two-word queue and the front
// hold register to in_tready
// ----------------------------------------------------------------------------
module implication_closure_engine_core #(
  parameter int ATTR_BITS = icl_pkg::DEF_ATTR_BITS,
  parameter int MAX_RULES = icl_pkg::DEF_MAX_RULES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // operation, rule_index, premise_mask, conclusion_mask, attribute_set
  input  logic [icl_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // closed_set, already_closed, status, zero pad
  output logic [icl_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic          q_push;
  logic          q_ready;
  icl_pkg::cmd_t q_in;
  logic          q_valid;
  logic          q_pop;
  icl_pkg::cmd_t q_out;

  icl_front #(
    .ATTR_BITS (ATTR_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_cmd     (q_in)
  );

  icl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_cmd   (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_out)
  );

  icl_back #(
    .ATTR_BITS (ATTR_BITS),
    .MAX_RULES (MAX_RULES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (q_out),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[tb/implication_closure_engine_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implication_closure_engine_core_tb
// Self-checking bench for the closure engine. A short table of directed words
// covers the empty table, bad replace indexes, multi-pass chaining and clear.
// Random episodes follow, each opening with a clear; the first fills the table
// past full. They mix replaces and closure queries built from sparse masks so
// that rules actually fire. A local copy of the rule table predicts the result
// words the directed rows do not give, and random idle gaps go on both streams.
// ----------------------------------------------------------------------------
module implication_closure_engine_core_tb;

  localparam int          ATTR_BITS    = icl_pkg::DEF_ATTR_BITS;
  localparam int          MAX_RULES    = icl_pkg::DEF_MAX_RULES;
  localparam logic [63:0] ATTR_MASK    =
    {icl_pkg::MASK_W{1'b1}} >> (icl_pkg::MASK_W - ATTR_BITS);
  localparam logic [63:0] ALL_ONES     = {icl_pkg::MASK_W{1'b1}};
  localparam int          TARGET_ITEMS = 1200;
  localparam int          CYCLE_LIMIT  = 30_000_000;

  typedef struct packed {
    logic [icl_pkg::MASK_W-1:0] closed;
    logic                       done;
    icl_pkg::status_t           status;
  } closure_result_t;

  typedef struct packed {
    icl_pkg::cmd_t   cmd;
    logic            known;
    closure_result_t want;
  } directed_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [icl_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [icl_pkg::OUT_TDATA_W-1:0] out_tdata;

  // predictor copy of the rule table
  logic [icl_pkg::MASK_W-1:0] prem_tbl [MAX_RULES];
  logic [icl_pkg::MASK_W-1:0] conc_tbl [MAX_RULES];
  int                         rule_cnt;

  closure_result_t   pending_results [$];
  directed_row_t     directed_rows [$];
  int                err_cnt = 0;
  int                cycle_cnt = 0;
  int                sent_items;
  int                stall_left = 0;
  bit                quiet_mode;

  implication_closure_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [icl_pkg::MASK_W-1:0] rand_mask();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [icl_pkg::MASK_W-1:0] sparse_mask(int nbits);
    logic [icl_pkg::MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < nbits; i++) m[6'($urandom_range(icl_pkg::MASK_W-1, 0))] = 1'b1;
    return m;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // forward chaining until no rule adds anything new
  function automatic logic [icl_pkg::MASK_W-1:0] chain_closure(
    logic [icl_pkg::MASK_W-1:0] x);
    bit grew;
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int r = 0; r < rule_cnt; r++) begin
        if ((prem_tbl[r] & ~x) == '0 && (conc_tbl[r] & ~x) != '0) begin
          x |= conc_tbl[r];
          grew = 1'b1;
        end
      end
    end
    return x;
  endfunction

  function automatic closure_result_t apply_to_table(icl_pkg::cmd_t c);
    closure_result_t res;
    logic [icl_pkg::MASK_W-1:0] prem, conc, aset;
    prem = c.prem & ATTR_MASK;
    conc = c.conc & ATTR_MASK;
    aset = c.set & ATTR_MASK;
    res = '{closed: '0, done: 1'b0, status: icl_pkg::ST_OK};
    case (c.op)
      icl_pkg::OP_APPEND: begin
        if (rule_cnt >= MAX_RULES) begin
          res.status = icl_pkg::ST_FULL;
        end else begin
          prem_tbl[rule_cnt] = prem;
          conc_tbl[rule_cnt] = conc;
          rule_cnt++;
        end
      end
      icl_pkg::OP_REPLACE: begin
        if (int'(c.idx) >= rule_cnt) begin
          res.status = icl_pkg::ST_BAD_INDEX;
        end else begin
          prem_tbl[c.idx] = prem;
          conc_tbl[c.idx] = conc;
        end
      end
      icl_pkg::OP_QUERY: begin
        res.closed = chain_closure(aset) & ATTR_MASK;
        res.done   = (res.closed == aset);
      end
      default: begin
        rule_cnt = 0;
      end
    endcase
    return res;
  endfunction

  function automatic directed_row_t row(icl_pkg::op_t op,
                                        logic [icl_pkg::IDX_W-1:0] idx,
                                        logic [icl_pkg::MASK_W-1:0] prem,
                                        logic [icl_pkg::MASK_W-1:0] conc,
                                        logic [icl_pkg::MASK_W-1:0] aset,
                                        logic known,
                                        logic [icl_pkg::MASK_W-1:0] w_closed,
                                        logic w_done, icl_pkg::status_t w_status);
    directed_row_t d;
    d.cmd.op      = op;
    d.cmd.idx     = idx;
    d.cmd.prem    = prem;
    d.cmd.conc    = conc;
    d.cmd.set     = aset;
    d.known       = known;
    d.want.closed = w_closed;
    d.want.done   = w_done;
    d.want.status = w_status;
    return d;
  endfunction

  function automatic void add_row(directed_row_t d);
    directed_rows.insert(directed_rows.size(), d);
  endfunction

  task automatic report_mismatch(string what, logic [icl_pkg::MASK_W-1:0] got,
                                 logic [icl_pkg::MASK_W-1:0] want);
    err_cnt++;
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // holds the word until taken, then predicts and maybe idles
  task automatic drive_item(icl_pkg::cmd_t c, logic known, closure_result_t want);
    closure_result_t res;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {c.set, c.conc, c.prem, c.idx, c.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = apply_to_table(c);
    pending_results.insert(pending_results.size(), known ? want : res);
    sent_items++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_result();
    closure_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("word with nothing pending", out_tdata[63:0], '0);
      return;
    end
    want = pending_results.pop_front();
    if (out_tdata[63:0] !== want.closed)
      report_mismatch("closed_set", out_tdata[63:0], want.closed);
    if (out_tdata[64] !== want.done)
      report_mismatch("already_closed", 64'(out_tdata[64]), 64'(want.done));
    if (out_tdata[66:65] !== want.status)
      report_mismatch("status", 64'(out_tdata[66:65]), 64'(want.status));
    if (out_tdata[icl_pkg::OUT_TDATA_W-1:67] !== '0)
      report_mismatch("pad", 64'(out_tdata[icl_pkg::OUT_TDATA_W-1:67]), 64'd0);
  endtask

  // result side: check on handshake, random back-pressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(3, 0) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    icl_pkg::cmd_t c;
    closure_result_t none;
    int ep_len, w_append, pick, r, episode;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    quiet_mode = 1'b0;
    sent_items = 0;
    rule_cnt   = 0;
    none       = '0;

    // empty table, bad replaces, multi-pass chain, clear
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, ALL_ONES,
                1'b1, ALL_ONES, 1'b1, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, '0,
                1'b1, '0, 1'b1, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_REPLACE, 6'd0, 64'h1, 64'h2, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_BAD_INDEX));
    add_row(row(icl_pkg::OP_REPLACE, 6'd63, ALL_ONES, ALL_ONES, ALL_ONES,
                1'b1, '0, 1'b0, icl_pkg::ST_BAD_INDEX));
    add_row(row(icl_pkg::OP_APPEND, 6'd0, '0, 64'h1, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_APPEND, 6'd0, 64'h4, 64'h8000_0000_0000_0000, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_APPEND, 6'd0, 64'h1, 64'h2, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_APPEND, 6'd0, 64'h2, 64'h4, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, '0,
                1'b0, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, ALL_ONES,
                1'b1, ALL_ONES, 1'b1, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, 64'h8000_0000_0000_0007,
                1'b0, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_REPLACE, 6'd4, 64'h1, 64'h1, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_BAD_INDEX));
    add_row(row(icl_pkg::OP_REPLACE, 6'd3, ALL_ONES, ALL_ONES, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE,
                1'b0, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_APPEND, 6'd0, 64'h8000_0000_0000_0000,
                64'h5555_5555_5555_5555, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA,
                1'b0, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_CLEAR, 6'd63, ALL_ONES, ALL_ONES, ALL_ONES,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, 64'h0123_4567_89AB_CDEF,
                1'b1, 64'h0123_4567_89AB_CDEF, 1'b1, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_REPLACE, 6'd0, 64'h3, 64'h4, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_BAD_INDEX));
    add_row(row(icl_pkg::OP_APPEND, 6'd0, ALL_ONES, '0, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_QUERY, 6'd0, '0, '0, ALL_ONES,
                1'b0, '0, 1'b0, icl_pkg::ST_OK));
    add_row(row(icl_pkg::OP_CLEAR, 6'd0, '0, '0, '0,
                1'b1, '0, 1'b0, icl_pkg::ST_OK));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      drive_item(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].want);

    // episodes open with a clear; the first one is append-heavy to hit full
    episode = 0;
    while (sent_items < TARGET_ITEMS) begin
      ep_len     = (episode == 0) ? 120 : $urandom_range(200, 40);
      w_append   = (episode == 0) ? 80 :
                   ($urandom_range(2, 0) == 0) ? 70 : $urandom_range(50, 25);
      quiet_mode = (episode > 0) && ($urandom_range(3, 0) == 0);
      c.op   = icl_pkg::OP_CLEAR;
      c.idx  = icl_pkg::IDX_W'($urandom);
      c.prem = rand_mask();
      c.conc = rand_mask();
      c.set  = rand_mask();
      drive_item(c, 1'b0, none);
      for (int k = 0; k < ep_len; k++) begin
        c.idx = icl_pkg::IDX_W'($urandom);
        r = $urandom_range(9, 0);
        if (r == 0)      c.prem = '0;
        else if (r <= 5) c.prem = sparse_mask($urandom_range(2, 1));
        else if (r == 6) c.prem = rand_mask() & 64'hFF;
        else             c.prem = rand_mask();
        c.conc = ($urandom_range(9, 0) < 6) ? sparse_mask($urandom_range(3, 1))
                                            : rand_mask();
        r = $urandom_range(9, 0);
        if (r == 0)      c.set = '0;
        else if (r == 1) c.set = ALL_ONES;
        else if (r <= 6) c.set = sparse_mask($urandom_range(4, 1));
        else             c.set = rand_mask();
        pick = $urandom_range(99, 0);
        if (pick < w_append) begin
          c.op = icl_pkg::OP_APPEND;
        end else if (pick < w_append + 15) begin
          c.op = icl_pkg::OP_REPLACE;
          if (rule_cnt > 0 && $urandom_range(3, 0) != 0)
            c.idx = icl_pkg::IDX_W'($urandom_range(rule_cnt - 1, 0));
        end else begin
          c.op = icl_pkg::OP_QUERY;
        end
        drive_item(c, 1'b0, none);
      end
      episode++;
    end
    in_tvalid  <= 1'b0;
    quiet_mode = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
